### design/polyphonic_triangle_synth_core_defines.svh
// Assertion macros shared by the polyphonic triangle synth RTL.
`ifndef POLYPHONIC_TRIANGLE_SYNTH_CORE_DEFINES_SVH
`define POLYPHONIC_TRIANGLE_SYNTH_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define PTS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define PTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/pts_pkg.sv
// Package with types, constants and the microcode table of the triangle synth.
package pts_pkg;

    localparam int VOICE_COUNT = 36;
    localparam int DECAY_TICKS = 16384;

    localparam int ADDR_W  = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
    localparam int DEC_W   = $clog2(DECAY_TICKS + 1);
    localparam int SUM_W   = $clog2(VOICE_COUNT * 255 + 1);
    localparam int CNT_W   = $clog2(VOICE_COUNT + 1);
    localparam int PHASE_W = 32;
    localparam int STEP_W  = 32;
    localparam int VOICE_W = 6;
    localparam int REG_W   = 4;

    localparam logic [ADDR_W-1:0] LAST_VOICE = ADDR_W'(VOICE_COUNT - 1);
    localparam logic [DEC_W-1:0]  DECAY_END  = DEC_W'(DECAY_TICKS);
    localparam logic [3:0]        ATTEN_MAX  = 4'd8;
    localparam logic [REG_W-1:0]  VOLUME_RESET = 4'd8;

    localparam logic [0:0] REG_REVERB = 1'b0;
    localparam logic [0:0] REG_VOLUME = 1'b1;

    typedef enum logic [1:0] {
        CMD_TICK        = 2'd0,
        CMD_SET_PRESSED = 2'd1,
        CMD_SET_HELD    = 2'd2,
        CMD_NONE        = 2'd3
    } cmd_t;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic               rising;
        logic [STEP_W-1:0]  pressed;
        logic [STEP_W-1:0]  held;
        logic [DEC_W-1:0]   decay;
        logic [3:0]         atten;
    } voice_rec_t;

    localparam voice_rec_t VOICE_RESET = '{
        phase: '0, rising: 1'b1, pressed: '0, held: '0, decay: '0, atten: '0
    };

    typedef enum logic [2:0] {
        ST_IDLE       = 3'd0,
        ST_WR_READ    = 3'd1,
        ST_WR_WRITE   = 3'd2,
        ST_TICK_START = 3'd3,
        ST_TICK_LOOP  = 3'd4,
        ST_TICK_DRAIN = 3'd5,
        ST_TICK_MIX   = 3'd6,
        ST_SPARE      = 3'd7
    } step_t;

    typedef enum logic [1:0] {
        RD_NONE,
        RD_CMD,
        RD_FIRST,
        RD_NEXT
    } rd_op_t;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_CMD,
        WR_VOICE
    } wr_op_t;

    typedef enum logic [1:0] {
        ACC_NONE,
        ACC_CLEAR,
        ACC_ADD
    } acc_op_t;

    typedef enum logic [2:0] {
        J_NEXT,
        J_ALWAYS,
        J_DISPATCH,
        J_LOOP,
        J_OUT_FREE
    } jmp_t;

    typedef struct packed {
        logic    in_ready;
        rd_op_t  rd_op;
        wr_op_t  wr_op;
        acc_op_t acc_op;
        logic    out_load;
        jmp_t    jmp;
        step_t   target;
    } ctrl_t;

    function automatic ctrl_t ucode_rom(input step_t step);
        ctrl_t c;
        c = '{in_ready: 1'b0, rd_op: RD_NONE, wr_op: WR_NONE, acc_op: ACC_NONE,
              out_load: 1'b0, jmp: J_ALWAYS, target: ST_IDLE};
        case (step)
            ST_IDLE: begin
                c.in_ready = 1'b1;
                c.jmp      = J_DISPATCH;
                c.target   = ST_TICK_START;
            end
            ST_WR_READ: begin
                c.rd_op = RD_CMD;
                c.jmp   = J_NEXT;
            end
            ST_WR_WRITE: begin
                c.wr_op  = WR_CMD;
                c.jmp    = J_ALWAYS;
                c.target = ST_IDLE;
            end
            ST_TICK_START: begin
                c.rd_op  = RD_FIRST;
                c.acc_op = ACC_CLEAR;
                c.jmp    = J_NEXT;
            end
            ST_TICK_LOOP: begin
                c.rd_op  = RD_NEXT;
                c.wr_op  = WR_VOICE;
                c.acc_op = ACC_ADD;
                c.jmp    = J_LOOP;
            end
            ST_TICK_DRAIN: begin
                c.acc_op = ACC_ADD;
                c.jmp    = J_NEXT;
            end
            ST_TICK_MIX: begin
                c.out_load = 1'b1;
                c.jmp      = J_OUT_FREE;
                c.target   = ST_IDLE;
            end
            default: begin
                c.jmp    = J_ALWAYS;
                c.target = ST_IDLE;
            end
        endcase
        return c;
    endfunction

endpackage

### design/pts_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      aclk,
    input  logic                                      wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                          wr_data,
    input  logic                                      rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

### design/polyphonic_triangle_synth_core.sv
// Top level of the polyphonic triangle synth: microcoded voice bank and mixer.
//
// Input channel (s_*): one transaction carries a command in s_tuser and a voice
// index and step value in s_tdata. A sample tick walks all voices and yields one
// result transaction on the m_* channel; a step write yields none, as does the
// unused command code.
// A step write reads, then writes its voice entry before the next item is taken.
// A sample tick walks the voices one voice per cycle through the read and write
// ports of the voice RAM, between setup, drain and mix steps. The result is
// registered and appears in the cycle after the mix step loads it.
// Configuration writes through cfg_we/cfg_index/cfg_wdata take effect at once;
// the user makes them while the block is idle, as the block does not enforce it.
// Reset is synchronous and active low. It marks every voice as unwritten, so
// each reads as silent and rising, sets reverb to 0 and volume to 8.
// When the receiver stalls, the finished sample waits in the output register;
// the next tick runs through its voices and then holds in the mix step until
// the output register is free.
`include "polyphonic_triangle_synth_core_defines.svh"

module polyphonic_triangle_synth_core
    import pts_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [39:0]       s_tdata,   // voice [5:0], step_value [37:6], zero [39:38]
    input  logic [1:0]        s_tuser,   // cmd [1:0]
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [15:0]       m_tdata,   // sample [7:0], sounding_voices [13:8], zero [15:14]
    input  logic              cfg_we,
    input  logic [0:0]        cfg_index,
    input  logic [REG_W-1:0]  cfg_wdata
);

    step_t               step_reg, step_next;
    ctrl_t               ctrl;
    cmd_t                cmd_reg;
    logic [VOICE_W-1:0]  voice_reg;
    logic [STEP_W-1:0]   step_val_reg;
    logic [ADDR_W-1:0]   cnt_reg;
    logic [ADDR_W-1:0]   rd_addr_reg;
    logic [VOICE_COUNT-1:0] valid_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [7:0]          level_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [REG_W-1:0]    reverb_reg;
    logic [REG_W-1:0]    volume_reg;
    logic                m_tvalid_reg;
    logic [7:0]          sample_reg;
    logic [5:0]          sounding_reg;

    logic                in_accept;
    logic                out_free;
    logic                out_load;
    logic                voice_in_range;
    logic                cnt_last;

    logic                ram_we, ram_re;
    logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
    voice_rec_t          ram_wdata;
    logic [$bits(voice_rec_t)-1:0] ram_rdata;
    voice_rec_t          rd_rec;
    voice_rec_t          cmd_rec;
    voice_rec_t          tick_rec;
    logic [7:0]          tick_level;
    logic                tick_sounding;

    logic [7:0]          sample_next;
    logic [5:0]          sounding_next;

    assign ctrl      = ucode_rom(step_reg);
    assign s_tready  = ctrl.in_ready && aresetn;
    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign out_load  = ctrl.out_load && out_free;
    assign cnt_last  = (cnt_reg == LAST_VOICE);
    assign voice_in_range = ({1'b0, voice_reg} < 7'(VOICE_COUNT));

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, sounding_reg, sample_reg};

    // Sequencer jump logic.
    always_comb begin
        case (ctrl.jmp)
            J_NEXT:     step_next = step_t'(step_reg + 3'd1);
            J_ALWAYS:   step_next = ctrl.target;
            J_DISPATCH: begin
                if (!in_accept) begin
                    step_next = step_reg;
                end else if (cmd_t'(s_tuser) == CMD_TICK) begin
                    step_next = ctrl.target;
                end else if (cmd_t'(s_tuser) == CMD_SET_PRESSED
                             || cmd_t'(s_tuser) == CMD_SET_HELD) begin
                    step_next = step_t'(step_reg + 3'd1);
                end else begin
                    step_next = step_reg;
                end
            end
            J_LOOP:     step_next = cnt_last ? step_t'(step_reg + 3'd1) : step_reg;
            J_OUT_FREE: step_next = out_free ? ctrl.target : step_reg;
            default:    step_next = ST_IDLE;
        endcase
    end

    // Voice RAM read and write ports.
    always_comb begin
        ram_re    = 1'b0;
        ram_raddr = '0;
        case (ctrl.rd_op)
            RD_CMD: begin
                ram_re    = 1'b1;
                ram_raddr = voice_reg[ADDR_W-1:0];
            end
            RD_FIRST: begin
                ram_re    = 1'b1;
                ram_raddr = '0;
            end
            RD_NEXT: begin
                ram_re    = !cnt_last;
                ram_raddr = cnt_reg + ADDR_W'(1);
            end
            default: begin
                ram_re    = 1'b0;
                ram_raddr = '0;
            end
        endcase
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = tick_rec;
        case (ctrl.wr_op)
            WR_CMD: begin
                ram_we    = voice_in_range;
                ram_waddr = voice_reg[ADDR_W-1:0];
                ram_wdata = cmd_rec;
            end
            WR_VOICE: begin
                ram_we    = 1'b1;
                ram_waddr = cnt_reg;
                ram_wdata = tick_rec;
            end
            default: begin
                ram_we    = 1'b0;
                ram_waddr = '0;
                ram_wdata = tick_rec;
            end
        endcase
    end

    pts_ram #(
        .WIDTH ($bits(voice_rec_t)),
        .DEPTH (VOICE_COUNT)
    ) u_voice_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // An entry never written since reset reads as a silent, rising voice.
    always_comb begin
        if ((32'(rd_addr_reg) < VOICE_COUNT) ? valid_reg[rd_addr_reg] : 1'b0) begin
            rd_rec = voice_rec_t'(ram_rdata);
        end else begin
            rd_rec = VOICE_RESET;
        end
    end

    always_comb begin
        cmd_rec = rd_rec;
        if (cmd_reg == CMD_SET_PRESSED) begin
            cmd_rec.pressed = step_val_reg;
        end else begin
            cmd_rec.held  = step_val_reg;
            cmd_rec.decay = '0;
            cmd_rec.atten = '0;
        end
    end

    // Per-voice tick update.
    always_comb begin
        logic [STEP_W-1:0]  step_sel;
        logic [PHASE_W:0]   phase_sum;
        logic [7:0]         lvl8;
        logic [DEC_W-1:0]   dec_inc;
        logic [3:0]         atten_inc;
        logic [31:0]        mask;

        step_sel  = (rd_rec.pressed != '0) ? rd_rec.pressed : rd_rec.held;
        phase_sum = {1'b0, rd_rec.phase} + {1'b0, step_sel[STEP_W-2:0], 1'b0};
        lvl8      = rd_rec.rising ? phase_sum[31:24] : ~phase_sum[31:24];
        dec_inc   = rd_rec.decay + DEC_W'(1);
        mask      = ({28'd0, reverb_reg} << 11) - 32'd1;
        atten_inc = rd_rec.atten;
        if (((32'(dec_inc) & mask) == 32'd0) && (rd_rec.atten < ATTEN_MAX)) begin
            atten_inc = rd_rec.atten + 4'd1;
        end

        tick_rec      = rd_rec;
        tick_level    = 8'd0;
        tick_sounding = 1'b0;
        if (rd_rec.pressed != '0) begin
            tick_sounding   = 1'b1;
            tick_rec.phase  = phase_sum[PHASE_W-1:0];
            tick_rec.rising = rd_rec.rising ^ phase_sum[PHASE_W];
            tick_level      = lvl8;
        end else if (rd_rec.held != '0 && reverb_reg != '0) begin
            tick_sounding = 1'b1;
            if (rd_rec.decay == DECAY_END) begin
                tick_rec.decay = '0;
                tick_rec.held  = '0;
                tick_rec.atten = '0;
            end else begin
                tick_rec.decay  = dec_inc;
                tick_rec.atten  = atten_inc;
                tick_rec.phase  = phase_sum[PHASE_W-1:0];
                tick_rec.rising = rd_rec.rising ^ phase_sum[PHASE_W];
                tick_level      = {1'b0, lvl8[7:1]} >> atten_inc;
            end
        end else begin
            tick_rec.phase = '0;
        end
    end

    // Mixer: volume shift, clamp and mute.
    always_comb begin
        logic [3:0]       corr;
        logic [3:0]       shift;
        logic [SUM_W-1:0] shifted;

        corr = 4'd8;
        if ((volume_reg == 4'd8 && 32'(count_reg) >= 32'd3)
            || (volume_reg == 4'd7 && 32'(count_reg) >= 32'd4)) begin
            corr = 4'd9;
        end
        shift   = (volume_reg < corr) ? (corr - volume_reg) : 4'd0;
        shifted = sum_reg >> shift;
        if (volume_reg == '0) begin
            sample_next = 8'd0;
        end else if (32'(shifted) > 32'd255) begin
            sample_next = 8'd255;
        end else begin
            sample_next = shifted[7:0];
        end
        sounding_next = (32'(count_reg) > 32'd63) ? 6'd63 : 6'(count_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg     <= ST_IDLE;
            valid_reg    <= '0;
            m_tvalid_reg <= 1'b0;
            reverb_reg   <= '0;
            volume_reg   <= VOLUME_RESET;
            cnt_reg      <= '0;
        end else begin
            step_reg <= step_next;

            if (cfg_we) begin
                case (cfg_index)
                    REG_REVERB: reverb_reg <= cfg_wdata;
                    REG_VOLUME: volume_reg <= cfg_wdata;
                    default:    reverb_reg <= reverb_reg;
                endcase
            end

            if (ram_we) begin
                valid_reg[ram_waddr] <= 1'b1;
            end

            if (ctrl.rd_op == RD_FIRST) begin
                cnt_reg <= '0;
            end else if (ctrl.wr_op == WR_VOICE && !cnt_last) begin
                cnt_reg <= cnt_reg + ADDR_W'(1);
            end

            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end

        if (in_accept) begin
            cmd_reg      <= cmd_t'(s_tuser);
            voice_reg    <= s_tdata[VOICE_W-1:0];
            step_val_reg <= s_tdata[VOICE_W+STEP_W-1:VOICE_W];
        end

        if (ram_re) begin
            rd_addr_reg <= ram_raddr;
        end

        case (ctrl.acc_op)
            ACC_CLEAR: begin
                sum_reg   <= '0;
                level_reg <= '0;
                count_reg <= '0;
            end
            ACC_ADD: begin
                sum_reg <= sum_reg + SUM_W'(level_reg);
                if (ctrl.wr_op == WR_VOICE) begin
                    level_reg <= tick_level;
                    count_reg <= count_reg + CNT_W'(tick_sounding);
                end else begin
                    level_reg <= '0;
                end
            end
            default: begin
                sum_reg <= sum_reg;
            end
        endcase

        if (out_load) begin
            sample_reg   <= sample_next;
            sounding_reg <= sounding_next;
        end
    end

    `PTS_ASSERT_SAME(a_ram_no_collision, aclk, aresetn, ram_we && ram_re, ram_waddr != ram_raddr, "voice RAM read and write hit the same entry")
    `PTS_ASSERT_SAME(a_ram_write_step, aclk, aresetn, ram_we, step_reg == ST_WR_WRITE || step_reg == ST_TICK_LOOP, "voice RAM written outside a write step")
    `PTS_ASSERT_SAME(a_loop_bound, aclk, aresetn, step_reg == ST_TICK_LOOP, cnt_reg <= LAST_VOICE, "voice counter ran past the last voice")
    `PTS_ASSERT_NEXT(a_load_returns, aclk, aresetn, out_load, m_tvalid && step_reg == ST_IDLE, "sample load did not present a transaction and return to idle")

endmodule
